// ===== hdl/stge_pkg.sv =====
// Shared constants, codes and interface types of the stabilizer tableau gate engine.
`timescale 1ns / 1ps

package stge_pkg;

    // Fixed field widths of the stream beats and the configuration register.
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int MODE_W     = 3;
    localparam int QUBIT_W    = 6;
    localparam int ROW_SEL_W  = 7;
    localparam int ACT_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = 2 * WORD_BITS + 1 + STATUS_W;

    // Qubit count in use after reset.
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

    // Operation codes carried in the input tuser.
    localparam logic [MODE_W-1:0] MODE_HADAMARD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PHASE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CNOT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EQUAL = 2'd2;

    // What the held item asks for once its fields have been checked.
    typedef enum logic [1:0] {
        KIND_GATE,
        KIND_WRITE,
        KIND_READ,
        KIND_SKIP
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic row_clr;
        logic gate_rd;
        logic cell_wr;
        logic res_cap;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  last_row;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== hdl/stge_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module stge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== hdl/stge_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module stge_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  stge_pkg::dp_status_t   stat,
    output stge_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GATE,
        S_DRAIN,
        S_CELL_WR,
        S_CELL_RD,
        S_CELL_CAP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // An item is taken only while nothing else is in flight.
    assign s_tready = (state_reg == S_IDLE);

    // Next state and the commands of each state.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.row_clr = 1'b1;
                unique case (stat.kind)
                    stge_pkg::KIND_GATE:  state_next = S_GATE;
                    stge_pkg::KIND_WRITE: state_next = S_CELL_WR;
                    stge_pkg::KIND_READ:  state_next = S_CELL_RD;
                    stge_pkg::KIND_SKIP:  state_next = S_FINISH;
                endcase
            end
            S_GATE:
            begin
                cmd.gate_rd = 1'b1;
                if (stat.last_row)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The datapath writes back the last row read.
                state_next = S_FINISH;
            end
            S_CELL_WR:
            begin
                cmd.cell_wr = 1'b1;
                state_next  = S_FINISH;
            end
            S_CELL_RD:
            begin
                state_next = S_CELL_CAP;
            end
            S_CELL_CAP:
            begin
                cmd.res_cap = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is never pushed into an occupied output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while the output register is busy");

    // Every accepted beat is decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DECODE))
        else $error("accepted beat not followed by decode");

    // A row sweep always ends with a write-back cycle before the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.gate_rd && stat.last_row) |=> (state_reg == S_DRAIN))
        else $error("row sweep ended without write-back");

endmodule

// ===== hdl/stge_datapath.sv =====
// Datapath: item registers, field checks, tableau memories, row update and result register.
`timescale 1ns / 1ps

module stge_datapath #(
    parameter int MAX_QUBITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [stge_pkg::ACT_W-1:0]           cfg_wr_data,
    input  logic [stge_pkg::IN_DATA_W-1:0]       in_tdata,
    input  logic [stge_pkg::MODE_W-1:0]          in_tuser,
    input  logic                                 out_tready,
    output logic                                 out_tvalid,
    output logic [stge_pkg::OUT_DATA_W-1:0]      out_tdata,
    input  stge_pkg::ctrl_cmd_t                  cmd,
    output stge_pkg::dp_status_t                 stat
);

    localparam int ROW_COUNT  = 2 * MAX_QUBITS;
    localparam int ROW_WORDS  = (MAX_QUBITS + stge_pkg::WORD_BITS - 1) / stge_pkg::WORD_BITS;
    localparam int CELL_COUNT = ROW_COUNT * ROW_WORDS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROW_COUNT);
    localparam int CNT_W      = (ROW_W > 8) ? ROW_W : 8;
    localparam int QW         = stge_pkg::QUBIT_W;
    localparam int BW         = stge_pkg::BIT_W;
    localparam int WB         = stge_pkg::WORD_BITS;

    // Configuration register.
    logic [stge_pkg::ACT_W-1:0] active_reg;

    // Fields of the item in work.
    logic [stge_pkg::MODE_W-1:0]    mode_reg;
    logic [QW-1:0]                  qa_reg;
    logic [QW-1:0]                  qb_reg;
    logic [stge_pkg::ROW_SEL_W-1:0] row_reg;
    logic                           word_reg;
    logic [WB-1:0]                  xin_reg;
    logic [WB-1:0]                  zin_reg;
    logic                           sin_reg;

    // Field checks.
    logic [stge_pkg::ACT_W-1:0]     nq;
    logic [7:0]                     rows_last;
    logic                           a_ok;
    logic                           b_ok;
    logic                           cell_ok;
    logic                           is_cnot;
    logic [stge_pkg::STATUS_W-1:0]  code;
    stge_pkg::kind_t                kind;

    // Row sweep.
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  wr_row_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] ka;
    logic [ADDR_W-1:0] kb;
    logic [ADDR_W-1:0] ka_reg;
    logic [ADDR_W-1:0] kb_reg;
    logic [ADDR_W-1:0] cell_addr;
    logic [ROW_W-1:0]  row_addr;

    // Memory ports.
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] x_wr_addr;
    logic [ADDR_W-1:0] z_wr_addr;
    logic [WB-1:0]     x_wr_data;
    logic [WB-1:0]     z_wr_data;
    logic [ROW_W-1:0]  s_rd_addr;
    logic [ROW_W-1:0]  s_wr_addr;
    logic              s_wr_data;
    logic              tab_we;
    logic [WB-1:0]     xa;
    logic [WB-1:0]     xb;
    logic [WB-1:0]     za;
    logic [WB-1:0]     zb;
    logic              sg;

    // Row update.
    logic [BW-1:0] pa;
    logic [BW-1:0] pb;
    logic [WB-1:0] ma;
    logic [WB-1:0] mb;
    logic [WB-1:0] x_gate;
    logic [WB-1:0] z_gate;
    logic          flip;
    logic          xc;
    logic          zc;
    logic          xt;
    logic          zt;

    // Result and output registers.
    logic [WB-1:0]                   res_x_reg;
    logic [WB-1:0]                   res_z_reg;
    logic                            res_s_reg;
    logic                            out_valid_reg;
    logic [stge_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= stge_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // Capture the fields of an accepted beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_tuser;
            qa_reg   <= in_tdata[5:0];
            qb_reg   <= in_tdata[11:6];
            row_reg  <= in_tdata[18:12];
            word_reg <= in_tdata[19];
            xin_reg  <= in_tdata[51:20];
            zin_reg  <= in_tdata[83:52];
            sin_reg  <= in_tdata[84];
        end
    end

    // Qubit and cell range checks, then the status code and item kind.
    always_comb
    begin
        nq        = (int'(active_reg) > MAX_QUBITS) ? stge_pkg::ACT_W'(MAX_QUBITS) : active_reg;
        rows_last = {nq, 1'b0} - 8'd1;
        a_ok      = ({1'b0, qa_reg} < nq);
        b_ok      = ({1'b0, qb_reg} < nq);
        cell_ok   = (int'(row_reg) < ROW_COUNT) && (int'(word_reg) < ROW_WORDS);
        is_cnot   = (mode_reg == stge_pkg::MODE_CNOT);
        code      = stge_pkg::ST_DONE;
        kind      = stge_pkg::KIND_SKIP;
        unique case (mode_reg)
            stge_pkg::MODE_HADAMARD, stge_pkg::MODE_PHASE:
            begin
                if (!a_ok)
                begin
                    code = stge_pkg::ST_RANGE;
                end
                else
                begin
                    kind = stge_pkg::KIND_GATE;
                end
            end
            stge_pkg::MODE_CNOT:
            begin
                if (!a_ok || !b_ok)
                begin
                    code = stge_pkg::ST_RANGE;
                end
                else if (qa_reg == qb_reg)
                begin
                    code = stge_pkg::ST_EQUAL;
                end
                else
                begin
                    kind = stge_pkg::KIND_GATE;
                end
            end
            stge_pkg::MODE_WRITE:
            begin
                if (!cell_ok)
                begin
                    code = stge_pkg::ST_RANGE;
                end
                else
                begin
                    kind = stge_pkg::KIND_WRITE;
                end
            end
            stge_pkg::MODE_READ:
            begin
                if (!cell_ok)
                begin
                    code = stge_pkg::ST_RANGE;
                end
                else
                begin
                    kind = stge_pkg::KIND_READ;
                end
            end
            default:
            begin
                code = stge_pkg::ST_RANGE;
            end
        endcase
    end

    // Word addresses of the gate qubits in the row being read, and of the addressed cell.
    always_comb
    begin
        ka        = ADDR_W'(int'(row_cnt_reg) * ROW_WORDS + int'(qa_reg[QW-1:BW]));
        kb        = ADDR_W'(int'(row_cnt_reg) * ROW_WORDS + int'(qb_reg[QW-1:BW]));
        cell_addr = ADDR_W'(int'(row_reg) * ROW_WORDS + int'(word_reg));
        row_addr  = ROW_W'(row_reg);
    end

    // Row counter; each row read is written back in the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.gate_rd;
            if (cmd.row_clr)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.gate_rd)
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
        end
    end

    // Write-back addresses of the row in flight.
    always_ff @(posedge clk)
    begin
        if (cmd.gate_rd)
        begin
            ka_reg     <= ka;
            kb_reg     <= kb;
            wr_row_reg <= row_cnt_reg;
        end
    end

    // Gate update of one row from the words just read.
    always_comb
    begin
        pa     = qa_reg[BW-1:0];
        pb     = qb_reg[BW-1:0];
        ma     = WB'(1) << pa;
        mb     = WB'(1) << pb;
        xc     = xa[pa];
        zc     = za[pa];
        xt     = xb[pb];
        zt     = zb[pb];
        x_gate = xa;
        z_gate = za;
        flip   = 1'b0;
        unique case (mode_reg)
            stge_pkg::MODE_HADAMARD:
            begin
                x_gate = xa ^ ((xa ^ za) & ma);
                z_gate = za ^ ((xa ^ za) & ma);
                flip   = |(xa & za & ma);
            end
            stge_pkg::MODE_PHASE:
            begin
                z_gate = za ^ (xa & ma);
                flip   = |(xa & za & ma);
            end
            stge_pkg::MODE_CNOT:
            begin
                x_gate = xb ^ (xc ? mb : '0);
                z_gate = za ^ (zt ? ma : '0);
                flip   = xc & zt & ~(xt ^ zc);
            end
            default:
            begin
                flip = 1'b0;
            end
        endcase
    end

    // Memory port selection between the row sweep and single-cell access.
    always_comb
    begin
        tab_we    = wr_pend_reg | cmd.cell_wr;
        rd_addr_a = cmd.gate_rd ? ka : cell_addr;
        s_rd_addr = cmd.gate_rd ? row_cnt_reg : row_addr;
        if (wr_pend_reg)
        begin
            x_wr_addr = is_cnot ? kb_reg : ka_reg;
            z_wr_addr = ka_reg;
            x_wr_data = x_gate;
            z_wr_data = z_gate;
            s_wr_addr = wr_row_reg;
            s_wr_data = sg ^ flip;
        end
        else
        begin
            x_wr_addr = cell_addr;
            z_wr_addr = cell_addr;
            x_wr_data = xin_reg;
            z_wr_data = zin_reg;
            s_wr_addr = row_addr;
            s_wr_data = sin_reg;
        end
    end

    // X bits of the tableau.
    stge_ram #(
        .WIDTH (WB),
        .DEPTH (CELL_COUNT)
    ) u_x_ram (
        .clk       (clk),
        .we        (tab_we),
        .wr_addr   (x_wr_addr),
        .wr_data   (x_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (kb),
        .rd_data_a (xa),
        .rd_data_b (xb)
    );

    // Z bits of the tableau.
    stge_ram #(
        .WIDTH (WB),
        .DEPTH (CELL_COUNT)
    ) u_z_ram (
        .clk       (clk),
        .we        (tab_we),
        .wr_addr   (z_wr_addr),
        .wr_data   (z_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (kb),
        .rd_data_a (za),
        .rd_data_b (zb)
    );

    // Row signs.
    stge_ram #(
        .WIDTH (1),
        .DEPTH (ROW_COUNT)
    ) u_sign_ram (
        .clk       (clk),
        .we        (tab_we),
        .wr_addr   (s_wr_addr),
        .wr_data   (s_wr_data),
        .rd_addr_a (s_rd_addr),
        .rd_addr_b (s_rd_addr),
        .rd_data_a (sg),
        .rd_data_b ()
    );

    // Result words: zero unless a read captures the addressed cell.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_x_reg <= '0;
            res_z_reg <= '0;
            res_s_reg <= 1'b0;
        end
        else if (cmd.res_cap)
        begin
            res_x_reg <= xa;
            res_z_reg <= za;
            res_s_reg <= sg;
        end
    end

    // Output register; it frees in the cycle its beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {(stge_pkg::OUT_DATA_W - stge_pkg::OUT_USED_W)'(0),
                             code, res_s_reg, res_z_reg, res_x_reg};
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.kind     = kind;
        stat.last_row = (CNT_W'(row_cnt_reg) == CNT_W'(rows_last));
        stat.out_free = !out_valid_reg || out_tready;
    end

    // A row write-back always follows the read of that row.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(cmd.gate_rd))
        else $error("row write-back without a preceding row read");

    // Sweep write-back and cell write never compete for the write ports.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_pend_reg && cmd.cell_wr))
        else $error("sweep and cell write in the same cycle");

    // A result appears on the output only when the controller loads one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output became valid without a result load");

endmodule

// ===== hdl/stabilizer_tableau_gate_engine.sv =====
// Top level of the stabilizer tableau gate engine: controller and datapath.
`timescale 1ns / 1ps
// Gate beats sweep rows 0 .. 2*N-1 (N = active qubits, capped at MAX_QUBITS) one row a cycle;
// the tableau memories' registered read puts each row's write-back in the next cycle.
// A new beat is taken only once the last result is loaded. Write beats: decode, cell write,
// finish; read beats: decode, cell read, capture, finish; rejected beats: decode, finish. The
// output register lets the next beat enter while a result waits. Reset sets active qubits to
// 64 and empties the output; the tableau is undefined until written and has no clearing pass.

module stabilizer_tableau_gate_engine #(
    parameter int MAX_QUBITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [stge_pkg::ACT_W-1:0]       cfg_wr_data,    // active_qubits
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // qubit_a[5:0], qubit_b[11:6], row_select[18:12], word_select[19], x_in[51:20],
    // z_in[83:52], sign_in[84], zero fill[87:85]
    input  logic [stge_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [stge_pkg::MODE_W-1:0]      s_axis_tuser,   // mode[2:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // x_out[31:0], z_out[63:32], sign_out[64], status[66:65], zero fill[71:67]
    output logic [stge_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    stge_pkg::ctrl_cmd_t  cmd;
    stge_pkg::dp_status_t stat;

    // Sequencing of each beat.
    stge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tableau storage, row update and result register.
    stge_datapath #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_tdata    (s_axis_tdata),
        .in_tuser    (s_axis_tuser),
        .out_tready  (m_axis_tready),
        .out_tvalid  (m_axis_tvalid),
        .out_tdata   (m_axis_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== tb/tableau_result_checker.sv =====
// Result checker for the stabilizer tableau gate engine: predicts every result beat and compares it.
`timescale 1ns / 1ps

module tableau_result_checker #(
    parameter int MAX_QUBITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [stge_pkg::ACT_W-1:0]      cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [stge_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [stge_pkg::MODE_W-1:0]     s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [stge_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              mismatch_count,
    output int                              pending_count
);

    localparam int WORD_BITS  = stge_pkg::WORD_BITS;
    localparam int STATUS_W   = stge_pkg::STATUS_W;
    localparam int MODE_W     = stge_pkg::MODE_W;
    localparam int IN_DATA_W  = stge_pkg::IN_DATA_W;
    localparam int QUBIT_W    = stge_pkg::QUBIT_W;
    localparam int ROW_SEL_W  = stge_pkg::ROW_SEL_W;
    localparam int OUT_USED_W = stge_pkg::OUT_USED_W;
    localparam int ROW_WORDS  = (MAX_QUBITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_COUNT  = 2 * MAX_QUBITS;

    // One result beat, last field in the lowest bits.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 sign;
        logic [WORD_BITS-1:0] z;
        logic [WORD_BITS-1:0] x;
    } tableau_result_t;

    // Shadow copy of the tableau and the qubit count.
    logic [WORD_BITS-1:0] x_words [ROW_COUNT * ROW_WORDS];
    logic [WORD_BITS-1:0] z_words [ROW_COUNT * ROW_WORDS];
    logic                 row_sign [ROW_COUNT];
    int                   active_count = int'(stge_pkg::ACTIVE_RESET);
    int                   fail_total   = 0;
    int                   queue_depth  = 0;

    tableau_result_t expected_results [$];
    tableau_result_t expected;
    tableau_result_t actual;

    assign mismatch_count = fail_total;
    assign pending_count  = queue_depth;

    // Applies one input beat to the shadow tableau and returns the result it should produce.
    function automatic tableau_result_t apply_item(input logic [MODE_W-1:0] mode,
                                                   input logic [IN_DATA_W-1:0] data);
        tableau_result_t      res;
        logic [QUBIT_W-1:0]   qa;
        logic [QUBIT_W-1:0]   qb;
        logic [ROW_SEL_W-1:0] row;
        logic                 word;
        int                   live;
        int                   r;
        int                   ka;
        int                   kb;
        int                   abit;
        int                   bbit;
        logic                 xa;
        logic                 za;
        logic                 xb;
        logic                 zb;
        qa   = data[5:0];
        qb   = data[11:6];
        row  = data[18:12];
        word = data[19];
        live = (active_count > MAX_QUBITS) ? MAX_QUBITS : active_count;
        abit = qa % WORD_BITS;
        bbit = qb % WORD_BITS;
        res  = '0;
        case (mode)
            stge_pkg::MODE_HADAMARD, stge_pkg::MODE_PHASE:
            begin
                if (qa >= live)
                    res.status = stge_pkg::ST_RANGE;
                else
                begin
                    for (r = 0; r < 2 * live; r++)
                    begin
                        ka = r * ROW_WORDS + qa / WORD_BITS;
                        xa = x_words[ka][abit];
                        za = z_words[ka][abit];
                        // Both gates flip the sign when X and Z are set together.
                        if (xa && za)
                            row_sign[r] = ~row_sign[r];
                        if (mode == stge_pkg::MODE_HADAMARD)
                        begin
                            x_words[ka][abit] = za;
                            z_words[ka][abit] = xa;
                        end
                        else
                            z_words[ka][abit] = za ^ xa;
                    end
                end
            end
            stge_pkg::MODE_CNOT:
            begin
                if (qa >= live || qb >= live)
                    res.status = stge_pkg::ST_RANGE;
                else if (qa == qb)
                    res.status = stge_pkg::ST_EQUAL;
                else
                begin
                    for (r = 0; r < 2 * live; r++)
                    begin
                        ka = r * ROW_WORDS + qa / WORD_BITS;
                        kb = r * ROW_WORDS + qb / WORD_BITS;
                        xa = x_words[ka][abit];
                        za = z_words[ka][abit];
                        xb = x_words[kb][bbit];
                        zb = z_words[kb][bbit];
                        if (xa && zb && !(xb ^ za))
                            row_sign[r] = ~row_sign[r];
                        x_words[kb][bbit] = xb ^ xa;
                        z_words[ka][abit] = za ^ zb;
                    end
                end
            end
            stge_pkg::MODE_WRITE, stge_pkg::MODE_READ:
            begin
                if (row >= ROW_COUNT || word >= ROW_WORDS)
                    res.status = stge_pkg::ST_RANGE;
                else if (mode == stge_pkg::MODE_WRITE)
                begin
                    ka           = row * ROW_WORDS + word;
                    x_words[ka]  = data[51:20];
                    z_words[ka]  = data[83:52];
                    row_sign[row] = data[84];
                end
                else
                begin
                    ka       = row * ROW_WORDS + word;
                    res.x    = x_words[ka];
                    res.z    = z_words[ka];
                    res.sign = row_sign[row];
                end
            end
            default:
                res.status = stge_pkg::ST_RANGE;
        endcase
        return res;
    endfunction

    // Reports one field of a result beat that differs from its prediction.
    task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            active_count = int'(stge_pkg::ACTIVE_RESET);
            queue_depth  = 0;
        end
        else
        begin
            // The user must write the register only while the block is idle; the block does not enforce it.
            if (cfg_wr_en)
                active_count = int'(cfg_wr_data);

            // Compare each result beat with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                actual = m_axis_tdata[OUT_USED_W-1:0];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, actual);
                    fail_total++;
                end
                else
                begin
                    expected = expected_results.pop_front();
                    check_field("x_out", expected.x, actual.x);
                    check_field("z_out", expected.z, actual.z);
                    check_field("sign_out", WORD_BITS'(expected.sign), WORD_BITS'(actual.sign));
                    check_field("status", WORD_BITS'(expected.status),
                                WORD_BITS'(actual.status));
                end
            end

            // Predict the result of each accepted input beat.
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_item(s_axis_tuser, s_axis_tdata));

            queue_depth = expected_results.size();
        end
    end

endmodule

// ===== tb/stabilizer_tableau_gate_engine_test.sv =====
// Testbench top for the stabilizer tableau gate engine: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module stabilizer_tableau_gate_engine_test;

    localparam int WORD_BITS     = stge_pkg::WORD_BITS;
    localparam int ROW_SEL_W     = stge_pkg::ROW_SEL_W;
    localparam int QUBIT_W       = stge_pkg::QUBIT_W;
    localparam int ACT_W         = stge_pkg::ACT_W;
    localparam int IN_DATA_W     = stge_pkg::IN_DATA_W;
    localparam int MODE_W        = stge_pkg::MODE_W;
    localparam int OUT_DATA_W    = stge_pkg::OUT_DATA_W;
    localparam int TABLE_ROWS    = 128;
    localparam int ROW_WORDS     = 2;
    localparam int LIVE_MAX      = 64;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SEGMENTS      = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int SWAP_IDLE_AT  = 500;
    localparam int STOP_IDLE_AT  = 1000;

    // Input beat fields, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]           fill;
        logic                 sign_in;
        logic [WORD_BITS-1:0] z_in;
        logic [WORD_BITS-1:0] x_in;
        logic                 word_sel;
        logic [ROW_SEL_W-1:0] row_sel;
        logic [QUBIT_W-1:0]   qubit_b;
        logic [QUBIT_W-1:0]   qubit_a;
    } item_fields_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [ACT_W-1:0]      cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_count;
    int send_idle_pct  = 31;
    int recv_idle_pct  = 61;
    int active_setting = int'(stge_pkg::ACTIVE_RESET);
    int items_sent     = 0;
    int idle_cycles    = 0;

    stabilizer_tableau_gate_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tableau_result_checker u_tableau_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls at random.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                       || cfg_wr_en))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL stabilizer_tableau_gate_engine");
            $finish;
        end
    end

    function automatic item_fields_t random_fields();
        item_fields_t f;
        f.fill     = '0;
        f.sign_in  = 1'($urandom_range(0, 1));
        f.z_in     = $urandom;
        f.x_in     = $urandom;
        f.word_sel = 1'($urandom_range(0, 1));
        f.row_sel  = ROW_SEL_W'($urandom_range(0, TABLE_ROWS - 1));
        f.qubit_b  = QUBIT_W'($urandom_range(0, LIVE_MAX - 1));
        f.qubit_a  = QUBIT_W'($urandom_range(0, LIVE_MAX - 1));
        return f;
    endfunction

    // Mostly qubits in use, sometimes any qubit to reach the range check.
    function automatic logic [QUBIT_W-1:0] pick_qubit();
        int live;
        live = (active_setting > LIVE_MAX) ? LIVE_MAX : active_setting;
        if (live > 0 && $urandom_range(0, 99) < 85)
            return QUBIT_W'($urandom_range(0, live - 1));
        return QUBIT_W'($urandom_range(0, LIVE_MAX - 1));
    endfunction

    // Offers one beat after a random gap and returns at the edge that takes it.
    task automatic send_item(input logic [MODE_W-1:0] mode, input item_fields_t f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        // Idling moves from the sender-light mix to the receiver-light mix, then stops.
        if (items_sent == SWAP_IDLE_AT)
        begin
            send_idle_pct = 61;
            recv_idle_pct = 31;
        end
        else if (items_sent == STOP_IDLE_AT)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic send_gate(input logic [MODE_W-1:0] mode, input int qa, input int qb);
        item_fields_t f;
        f         = random_fields();
        f.qubit_a = QUBIT_W'(qa);
        f.qubit_b = QUBIT_W'(qb);
        send_item(mode, f);
    endtask

    task automatic send_cell(input logic [MODE_W-1:0] mode, input int row, input int word,
                             input logic [WORD_BITS-1:0] x, input logic [WORD_BITS-1:0] z,
                             input logic s);
        item_fields_t f;
        f          = random_fields();
        f.row_sel  = ROW_SEL_W'(row);
        f.word_sel = 1'(word);
        f.x_in     = x;
        f.z_in     = z;
        f.sign_in  = s;
        send_item(mode, f);
    endtask

    task automatic send_random_item();
        item_fields_t     f;
        logic [MODE_W-1:0] mode;
        int               roll;
        f    = random_fields();
        roll = $urandom_range(0, 99);
        if (roll < 20)
            mode = stge_pkg::MODE_HADAMARD;
        else if (roll < 40)
            mode = stge_pkg::MODE_PHASE;
        else if (roll < 62)
            mode = stge_pkg::MODE_CNOT;
        else if (roll < 77)
            mode = stge_pkg::MODE_WRITE;
        else if (roll < 94)
            mode = stge_pkg::MODE_READ;
        else
            mode = stge_pkg::MODE_READ + MODE_W'($urandom_range(1, 3));
        f.qubit_a = pick_qubit();
        f.qubit_b = ($urandom_range(0, 19) == 0) ? f.qubit_a : pick_qubit();
        send_item(mode, f);
    endtask

    // Drains all results, then writes the qubit count while the block is idle.
    task automatic set_active_qubits(input int value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ACT_W'(value);
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        active_setting  = value;
    endtask

    initial
    begin
        int seg_active [SEGMENTS];
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Load every row word so that no gate or read touches an unwritten entry.
        for (int row = 0; row < TABLE_ROWS; row++)
        begin
            for (int word = 0; word < ROW_WORDS; word++)
                send_cell(stge_pkg::MODE_WRITE, row, word, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
        end

        // Directed: field extremes, every operation and the error cases.
        send_cell(stge_pkg::MODE_WRITE, 0, 0, '1, '1, 1'b1);
        send_cell(stge_pkg::MODE_READ, 0, 0, '0, '0, 1'b0);
        send_cell(stge_pkg::MODE_WRITE, TABLE_ROWS - 1, 1, '0, '0, 1'b0);
        send_cell(stge_pkg::MODE_READ, TABLE_ROWS - 1, 1, '1, '1, 1'b1);
        send_gate(stge_pkg::MODE_HADAMARD, 0, 0);
        send_gate(stge_pkg::MODE_HADAMARD, LIVE_MAX - 1, 0);
        send_gate(stge_pkg::MODE_PHASE, 31, 0);
        send_gate(stge_pkg::MODE_PHASE, 32, 0);
        send_gate(stge_pkg::MODE_CNOT, 0, LIVE_MAX - 1);
        send_gate(stge_pkg::MODE_CNOT, LIVE_MAX - 1, 32);
        send_gate(stge_pkg::MODE_CNOT, 5, 5);
        for (int k = 1; k <= 3; k++)
            send_gate(stge_pkg::MODE_READ + MODE_W'(k), 0, 1);
        send_cell(stge_pkg::MODE_READ, 0, 0, '0, '0, 1'b0);
        send_cell(stge_pkg::MODE_READ, TABLE_ROWS - 1, 1, '0, '0, 1'b0);

        // A single qubit: only qubit 0 is in range.
        set_active_qubits(1);
        send_gate(stge_pkg::MODE_HADAMARD, 0, 0);
        send_gate(stge_pkg::MODE_HADAMARD, 1, 0);
        send_gate(stge_pkg::MODE_CNOT, 0, 0);
        send_gate(stge_pkg::MODE_CNOT, 0, 1);
        send_gate(stge_pkg::MODE_PHASE, 0, 0);

        // No qubits: every gate is out of range.
        set_active_qubits(0);
        send_gate(stge_pkg::MODE_HADAMARD, 0, 0);
        send_gate(stge_pkg::MODE_CNOT, 0, 0);

        // A count above the tableau size acts as the full size.
        set_active_qubits(127);
        send_gate(stge_pkg::MODE_CNOT, 62, 63);
        send_cell(stge_pkg::MODE_READ, TABLE_ROWS - 1, 0, '0, '0, 1'b0);

        // Random items over several qubit counts.
        seg_active    = '{64, 127, 1, 2, 33, 0, 64, 100, 32, 64};
        seg_active[6] = $urandom_range(3, 63);
        for (int s = 0; s < SEGMENTS; s++)
        begin
            set_active_qubits(seg_active[s]);
            repeat (RANDOM_ITEMS / SEGMENTS) send_random_item();
        end

        // Wait for the last results, then for any stray beat.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (2 * LIVE_MAX + 8) @(negedge clk);

        if (mismatch_count == 0)
            $display("PASS stabilizer_tableau_gate_engine");
        else
            $display("FAIL stabilizer_tableau_gate_engine");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/stge_pkg.sv
hdl/stge_ram.sv
hdl/stge_ctrl.sv
hdl/stge_datapath.sv
hdl/stabilizer_tableau_gate_engine.sv
tb/tableau_result_checker.sv
tb/stabilizer_tableau_gate_engine_test.sv
